@@ src/ebam_pkg.sv @@
// Package with widths, register codes, controller states and shared types of the meter.
package ebam_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int FRAC_BITS   = 16;

  // Weight format of the smoother (unsigned Q0.16).
  localparam int Q_BITS      = 16;
  localparam int LEN_W       = 8;
  localparam int GAIN_W      = 14;
  localparam int OFFSET_W    = 11;
  localparam int READING_W   = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam int SMOOTH_W    = SAMPLE_BITS + FRAC_BITS;
  localparam int SUM_W       = SMOOTH_W + LEN_W;
  localparam int SUM_LO_W    = SUM_W / 2;
  localparam int SUM_HI_W    = SUM_W - SUM_LO_W;
  localparam int LO_PROD_W   = SUM_LO_W + GAIN_W;
  localparam int HI_PROD_W   = SUM_HI_W + GAIN_W;
  localparam int SCALE_W     = SUM_W + GAIN_W;
  localparam int DIVIDEND_W  = SCALE_W - FRAC_BITS;
  localparam int DIVISOR_W   = LEN_W + SAMPLE_BITS;
  localparam int RESULT_W    = DIVIDEND_W + 2;

  // Shared multiplier, signed operands.
  localparam int MUL_A_W     = SMOOTH_W + 2;
  localparam int MUL_B_W     = Q_BITS + 1;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;

  localparam int IN_DATA_W   = 2 * SAMPLE_BITS;
  localparam int IN_TDATA_W  = ((IN_DATA_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 2 * READING_W;

  localparam logic [Q_BITS-1:0]   RST_SMOOTHING_FACTOR = Q_BITS'(3277);
  localparam logic [LEN_W-1:0]    RST_BLOCK_LENGTH     = LEN_W'(50);
  localparam logic [GAIN_W-1:0]   RST_VOLTAGE_GAIN     = GAIN_W'(6679);
  localparam logic [OFFSET_W-1:0] RST_VOLTAGE_OFFSET   = OFFSET_W'(3);
  localparam logic [GAIN_W-1:0]   RST_CURRENT_GAIN     = GAIN_W'(3289);
  localparam logic [OFFSET_W-1:0] RST_CURRENT_OFFSET   = OFFSET_W'(-12);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SMOOTHING_FACTOR = 3'd0,
    REG_BLOCK_LENGTH     = 3'd1,
    REG_VOLTAGE_GAIN     = 3'd2,
    REG_VOLTAGE_OFFSET   = 3'd3,
    REG_CURRENT_GAIN     = 3'd4,
    REG_CURRENT_OFFSET   = 3'd5
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_V,
    ST_UPD_V,
    ST_UPD_C,
    ST_ACC_C,
    ST_SC_VLO,
    ST_SC_VHI,
    ST_SC_CLO,
    ST_SC_CHI,
    ST_SC_CADD,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_OUTPUT
  } state_e;

  typedef enum logic [2:0] {
    MUL_SMOOTH_V,
    MUL_SMOOTH_C,
    MUL_SUM_V_LO,
    MUL_SUM_V_HI,
    MUL_SUM_C_LO,
    MUL_SUM_C_HI
  } mul_sel_e;

  typedef struct packed {
    logic [Q_BITS-1:0]          smoothing_factor;
    logic [LEN_W-1:0]           block_length;
    logic [GAIN_W-1:0]          voltage_gain;
    logic signed [OFFSET_W-1:0] voltage_offset;
    logic [GAIN_W-1:0]          current_gain;
    logic signed [OFFSET_W-1:0] current_offset;
  } cfg_t;

  typedef struct packed {
    logic     latch_in;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     upd_smooth_v;
    logic     upd_smooth_c;
    logic     acc_v;
    logic     acc_c;
    logic     prod_v_lo_ld;
    logic     prod_v_hi_add;
    logic     prod_c_lo_ld;
    logic     prod_c_hi_add;
    logic     div_start;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic block_done;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

@@ src/ebam_divider.sv @@
// Restoring divider that produces one quotient bit per cycle.
module ebam_divider (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [ebam_pkg::DIVIDEND_W-1:0]  dividend_i,
  input  logic [ebam_pkg::DIVISOR_W-1:0]   divisor_i,
  output logic                             busy_o,
  output logic [ebam_pkg::DIVIDEND_W-1:0]  quotient_o
);
  import ebam_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  div_q, div_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W:0]    trial;

  always_comb begin
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    div_d   = div_q;
    quo_d   = quo_q;
    shifted = {rem_q, quo_q[DIVIDEND_W-1]};
    trial   = shifted - {1'b0, div_q};
    if (start_i) begin
      cnt_d = CNT_W'(DIVIDEND_W);
      rem_d = '0;
      div_d = divisor_i;
      quo_d = dividend_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      // The dividend shifts out at the top while quotient bits shift in below.
      if (!trial[DIVISOR_W]) begin
        rem_d = trial[DIVISOR_W-1:0];
        quo_d = {quo_q[DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[DIVISOR_W-1:0];
        quo_d = {quo_q[DIVIDEND_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
    quo_q <= quo_d;
  end

  assign busy_o     = (cnt_q != '0);
  assign quotient_o = quo_q;

endmodule

@@ src/ebam_ctrl.sv @@
// Controller state machine that sequences the smoother, the block sums and the readout.
module ebam_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ebam_pkg::status_t status_i,
  output ebam_pkg::cmd_t    cmd_o
);
  import ebam_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.mul_sel = MUL_SMOOTH_V;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = ST_MUL_V;
        end
      end
      ST_MUL_V: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_SMOOTH_V;
        state_d       = ST_UPD_V;
      end
      ST_UPD_V: begin
        cmd_o.upd_smooth_v = 1'b1;
        cmd_o.mul_en       = 1'b1;
        cmd_o.mul_sel      = MUL_SMOOTH_C;
        state_d            = ST_UPD_C;
      end
      ST_UPD_C: begin
        cmd_o.upd_smooth_c = 1'b1;
        cmd_o.acc_v        = 1'b1;
        state_d            = ST_ACC_C;
      end
      ST_ACC_C: begin
        cmd_o.acc_c = 1'b1;
        state_d     = status_i.block_done ? ST_SC_VLO : ST_IDLE;
      end
      ST_SC_VLO: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_SUM_V_LO;
        state_d       = ST_SC_VHI;
      end
      ST_SC_VHI: begin
        cmd_o.prod_v_lo_ld = 1'b1;
        cmd_o.mul_en       = 1'b1;
        cmd_o.mul_sel      = MUL_SUM_V_HI;
        state_d            = ST_SC_CLO;
      end
      ST_SC_CLO: begin
        cmd_o.prod_v_hi_add = 1'b1;
        cmd_o.mul_en        = 1'b1;
        cmd_o.mul_sel       = MUL_SUM_C_LO;
        state_d             = ST_SC_CHI;
      end
      ST_SC_CHI: begin
        cmd_o.prod_c_lo_ld = 1'b1;
        cmd_o.mul_en       = 1'b1;
        cmd_o.mul_sel      = MUL_SUM_C_HI;
        state_d            = ST_SC_CADD;
      end
      ST_SC_CADD: begin
        cmd_o.prod_c_hi_add = 1'b1;
        state_d             = ST_DIV_START;
      end
      ST_DIV_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (status_i.div_done) begin
          state_d = ST_OUTPUT;
        end
      end
      ST_OUTPUT: begin
        // Hold here until the output register can take the reading.
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ src/ebam_datapath.sv @@
// Datapath with smoother state, block sums, shared multiplier, dividers and output register.
module ebam_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ebam_pkg::cfg_t                     cfg_i,
  input  ebam_pkg::cmd_t                     cmd_i,
  output ebam_pkg::status_t                  status_o,
  input  logic [ebam_pkg::SAMPLE_BITS-1:0]   voltage_sample_i,
  input  logic [ebam_pkg::SAMPLE_BITS-1:0]   current_sample_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [ebam_pkg::READING_W-1:0]     voltage_reading_o,
  output logic [ebam_pkg::READING_W-1:0]     current_reading_o
);
  import ebam_pkg::*;

  logic [SAMPLE_BITS-1:0] x_v_q, x_c_q;
  logic [SMOOTH_W-1:0]    smooth_v_q, smooth_c_q;
  logic [SUM_W-1:0]       sum_v_q, sum_c_q;
  logic [LEN_W-1:0]       count_q;
  logic [LEN_W-1:0]       len_eff;
  logic signed [PROD_W-1:0] p_q;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [SMOOTH_W:0]  diff_v, diff_c;
  logic [SCALE_W-1:0]     prod_v_q, prod_c_q;
  logic [DIVISOR_W-1:0]   divisor;
  logic                   busy_v, busy_c;
  logic [DIVIDEND_W-1:0]  quo_v, quo_c;
  logic                   out_valid_q;
  logic [READING_W-1:0]   read_v_q, read_c_q;
  logic [READING_W-1:0]   read_v_d, read_c_d;

  function automatic logic [READING_W-1:0] clamp_reading(
    input logic [DIVIDEND_W-1:0]  quo,
    input logic [OFFSET_W-1:0]    offset
  );
    logic signed [RESULT_W-1:0] r;
    r = $signed({2'b00, quo}) + $signed({{(RESULT_W-OFFSET_W){offset[OFFSET_W-1]}}, offset});
    if (r[RESULT_W-1]) begin
      return '0;
    end else if (r[RESULT_W-2:READING_W] != '0) begin
      return '1;
    end else begin
      return r[READING_W-1:0];
    end
  endfunction

  assign len_eff = (cfg_i.block_length == '0) ? LEN_W'(1) : cfg_i.block_length;
  // Divisor is len_eff * (2^S - 1); the 2^F factor is taken off the dividend.
  assign divisor = {len_eff, {SAMPLE_BITS{1'b0}}} - DIVISOR_W'(len_eff);

  // Smoother step: s' = s + floor(q * ((x << F) - s) / 2^16).
  assign diff_v = $signed({1'b0, x_v_q, {FRAC_BITS{1'b0}}}) - $signed({1'b0, smooth_v_q});
  assign diff_c = $signed({1'b0, x_c_q, {FRAC_BITS{1'b0}}}) - $signed({1'b0, smooth_c_q});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_sel)
      MUL_SMOOTH_V: begin
        mul_a = {diff_v[SMOOTH_W], diff_v};
        mul_b = {1'b0, cfg_i.smoothing_factor};
      end
      MUL_SMOOTH_C: begin
        mul_a = {diff_c[SMOOTH_W], diff_c};
        mul_b = {1'b0, cfg_i.smoothing_factor};
      end
      MUL_SUM_V_LO: begin
        mul_a = {{(MUL_A_W-SUM_LO_W){1'b0}}, sum_v_q[SUM_LO_W-1:0]};
        mul_b = {{(MUL_B_W-GAIN_W){1'b0}}, cfg_i.voltage_gain};
      end
      MUL_SUM_V_HI: begin
        mul_a = {{(MUL_A_W-SUM_HI_W){1'b0}}, sum_v_q[SUM_W-1:SUM_LO_W]};
        mul_b = {{(MUL_B_W-GAIN_W){1'b0}}, cfg_i.voltage_gain};
      end
      MUL_SUM_C_LO: begin
        mul_a = {{(MUL_A_W-SUM_LO_W){1'b0}}, sum_c_q[SUM_LO_W-1:0]};
        mul_b = {{(MUL_B_W-GAIN_W){1'b0}}, cfg_i.current_gain};
      end
      MUL_SUM_C_HI: begin
        mul_a = {{(MUL_A_W-SUM_HI_W){1'b0}}, sum_c_q[SUM_W-1:SUM_LO_W]};
        mul_b = {{(MUL_B_W-GAIN_W){1'b0}}, cfg_i.current_gain};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      x_v_q <= voltage_sample_i;
      x_c_q <= current_sample_i;
    end
    if (cmd_i.mul_en) begin
      p_q <= mul_a * mul_b;
    end
    if (cmd_i.prod_v_lo_ld) begin
      prod_v_q <= SCALE_W'(p_q[LO_PROD_W-1:0]);
    end
    if (cmd_i.prod_v_hi_add) begin
      prod_v_q <= prod_v_q + {p_q[HI_PROD_W-1:0], {SUM_LO_W{1'b0}}};
    end
    if (cmd_i.prod_c_lo_ld) begin
      prod_c_q <= SCALE_W'(p_q[LO_PROD_W-1:0]);
    end
    if (cmd_i.prod_c_hi_add) begin
      prod_c_q <= prod_c_q + {p_q[HI_PROD_W-1:0], {SUM_LO_W{1'b0}}};
    end
    if (cmd_i.out_load) begin
      read_v_q <= read_v_d;
      read_c_q <= read_c_d;
    end
  end

  // The convex update keeps the true result in range, so modular addition is exact.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_v_q  <= '0;
      smooth_c_q  <= '0;
      sum_v_q     <= '0;
      sum_c_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.upd_smooth_v) begin
        smooth_v_q <= smooth_v_q + p_q[Q_BITS +: SMOOTH_W];
      end
      if (cmd_i.upd_smooth_c) begin
        smooth_c_q <= smooth_c_q + p_q[Q_BITS +: SMOOTH_W];
      end
      if (cmd_i.acc_v) begin
        sum_v_q <= sum_v_q + SUM_W'(smooth_v_q);
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.acc_c) begin
        sum_c_q <= sum_c_q + SUM_W'(smooth_c_q);
      end
      if (cmd_i.out_load) begin
        sum_v_q     <= '0;
        sum_c_q     <= '0;
        count_q     <= '0;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  ebam_divider u_div_v (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (prod_v_q[SCALE_W-1:FRAC_BITS]),
    .divisor_i  (divisor),
    .busy_o     (busy_v),
    .quotient_o (quo_v)
  );

  ebam_divider u_div_c (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (prod_c_q[SCALE_W-1:FRAC_BITS]),
    .divisor_i  (divisor),
    .busy_o     (busy_c),
    .quotient_o (quo_c)
  );

  assign read_v_d = clamp_reading(quo_v, cfg_i.voltage_offset);
  assign read_c_d = clamp_reading(quo_c, cfg_i.current_offset);

  assign status_o.block_done = (count_q >= len_eff);
  assign status_o.div_done   = !busy_v && !busy_c;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o       = out_valid_q;
  assign voltage_reading_o = read_v_q;
  assign current_reading_o = read_c_q;

endmodule

@@ src/ema_block_average_meter.sv @@
// Two-channel smoothing meter: configuration registers and the controller and datapath.
//
// Usage: each request on the s_axis channel carries one voltage and one current
// converter code. Both channels pass through a first-order exponential smoother
// whose state persists across blocks; the smoothed values are summed, and after
// block_length requests one request on m_axis carries both scaled readings. The user
// must send configuration writes on the cfg channel (always ready) only while the
// block is idle, which the block does not enforce; indexes 6 and 7 are ignored.
// Pacing: a request is taken only in the idle state; the four sequencer steps after
// acceptance, set by the single shared multiplier used twice per request, must finish
// before the next is taken. At the end of a block the scaling steps run on the multiplier,
// then the dividers start and produce one quotient bit per cycle until they finish,
// and the output step loads the reading.
// Reset loads the default register values and clears the smoother state, the sums,
// the count and the output valid flag. When the receiver stalls, the finished reading
// waits in the output register; a following block completes and then holds until
// the register is free, with s_axis_tready low meanwhile.
module ema_block_average_meter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // tdata: voltage_sample [11:0], current_sample [23:12]
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [ebam_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // tdata: voltage_reading [15:0], current_reading [31:16]
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [ebam_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ebam_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ebam_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import ebam_pkg::*;

  cfg_t    cfg_q;
  cmd_t    cmd;
  status_t status;
  logic [READING_W-1:0] voltage_reading;
  logic [READING_W-1:0] current_reading;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.smoothing_factor <= RST_SMOOTHING_FACTOR;
      cfg_q.block_length     <= RST_BLOCK_LENGTH;
      cfg_q.voltage_gain     <= RST_VOLTAGE_GAIN;
      cfg_q.voltage_offset   <= RST_VOLTAGE_OFFSET;
      cfg_q.current_gain     <= RST_CURRENT_GAIN;
      cfg_q.current_offset   <= RST_CURRENT_OFFSET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SMOOTHING_FACTOR: cfg_q.smoothing_factor <= cfg_data_i[Q_BITS-1:0];
        REG_BLOCK_LENGTH:     cfg_q.block_length     <= cfg_data_i[LEN_W-1:0];
        REG_VOLTAGE_GAIN:     cfg_q.voltage_gain     <= cfg_data_i[GAIN_W-1:0];
        REG_VOLTAGE_OFFSET:   cfg_q.voltage_offset   <= cfg_data_i[OFFSET_W-1:0];
        REG_CURRENT_GAIN:     cfg_q.current_gain     <= cfg_data_i[GAIN_W-1:0];
        REG_CURRENT_OFFSET:   cfg_q.current_offset   <= cfg_data_i[OFFSET_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ebam_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ebam_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .cmd_i             (cmd),
    .status_o          (status),
    .voltage_sample_i  (s_axis_tdata[SAMPLE_BITS-1:0]),
    .current_sample_i  (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .voltage_reading_o (voltage_reading),
    .current_reading_o (current_reading)
  );

  assign m_axis_tdata = {current_reading, voltage_reading};

endmodule

@@ sim/tb_ema_block_average_meter.sv @@
// Self-checking testbench for the two-channel smoothing meter with block-mean readout.

typedef logic [ebam_pkg::SMOOTH_W-1:0]  smooth_t;
typedef logic [ebam_pkg::SUM_W-1:0]     block_sum_t;
typedef logic [ebam_pkg::READING_W-1:0] reading_t;

typedef struct packed {
  reading_t current;
  reading_t voltage;
} reading_pair_t;

// Tracks the meter state, predicts each reading pair and matches it against the block.
class ema_reading_tracker;
  ebam_pkg::cfg_t                  regs;
  smooth_t                         voltage_smooth;
  smooth_t                         current_smooth;
  block_sum_t                      voltage_total;
  block_sum_t                      current_total;
  logic [ebam_pkg::LEN_W-1:0]      samples_in_block;
  reading_pair_t                   pending_readings[$];
  int                              failures;
  int                              readings_matched;

  function new();
    regs.smoothing_factor = ebam_pkg::RST_SMOOTHING_FACTOR;
    regs.block_length     = ebam_pkg::RST_BLOCK_LENGTH;
    regs.voltage_gain     = ebam_pkg::RST_VOLTAGE_GAIN;
    regs.voltage_offset   = ebam_pkg::RST_VOLTAGE_OFFSET;
    regs.current_gain     = ebam_pkg::RST_CURRENT_GAIN;
    regs.current_offset   = ebam_pkg::RST_CURRENT_OFFSET;
    voltage_smooth   = '0;
    current_smooth   = '0;
    voltage_total    = '0;
    current_total    = '0;
    samples_in_block = '0;
    failures         = 0;
    readings_matched = 0;
  endfunction

  function int pending();
    return pending_readings.size();
  endfunction

  function void load_register(logic [ebam_pkg::CFG_IDX_W-1:0] idx,
                              logic [ebam_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      ebam_pkg::REG_SMOOTHING_FACTOR: regs.smoothing_factor = data[ebam_pkg::Q_BITS-1:0];
      ebam_pkg::REG_BLOCK_LENGTH:     regs.block_length     = data[ebam_pkg::LEN_W-1:0];
      ebam_pkg::REG_VOLTAGE_GAIN:     regs.voltage_gain     = data[ebam_pkg::GAIN_W-1:0];
      ebam_pkg::REG_VOLTAGE_OFFSET:   regs.voltage_offset   = data[ebam_pkg::OFFSET_W-1:0];
      ebam_pkg::REG_CURRENT_GAIN:     regs.current_gain     = data[ebam_pkg::GAIN_W-1:0];
      ebam_pkg::REG_CURRENT_OFFSET:   regs.current_offset   = data[ebam_pkg::OFFSET_W-1:0];
      default: ;
    endcase
  endfunction

  // The new value is a convex mix of the sample and the old value, so it fits its width.
  function smooth_t smooth_step(smooth_t prev, logic [ebam_pkg::SAMPLE_BITS-1:0] x);
    logic [63:0] q;
    logic [63:0] acc;
    q   = 64'(regs.smoothing_factor);
    acc = q * (64'(x) << ebam_pkg::FRAC_BITS) + (64'd65536 - q) * 64'(prev);
    return smooth_t'(acc >> ebam_pkg::Q_BITS);
  endfunction

  function reading_t scale_reading(block_sum_t total, logic [ebam_pkg::GAIN_W-1:0] gain,
                                   logic signed [ebam_pkg::OFFSET_W-1:0] offset,
                                   int unsigned len);
    logic [63:0] divisor;
    logic [63:0] quo;
    longint      r;
    divisor = (64'(len) * ((64'd1 << ebam_pkg::SAMPLE_BITS) - 64'd1)) << ebam_pkg::FRAC_BITS;
    quo     = (64'(total) * 64'(gain)) / divisor;
    if (quo > 64'h7FFF_FFFF) quo = 64'h7FFF_FFFF;
    r = longint'(quo) + longint'($signed(offset));
    if (r < 0) r = 0;
    if (r > 65535) r = 65535;
    return reading_t'(r);
  endfunction

  function void take_sample(logic [ebam_pkg::SAMPLE_BITS-1:0] v,
                            logic [ebam_pkg::SAMPLE_BITS-1:0] c);
    int unsigned   len;
    reading_pair_t due;
    len = (regs.block_length == 0) ? 1 : int'(regs.block_length);
    voltage_smooth   = smooth_step(voltage_smooth, v);
    current_smooth   = smooth_step(current_smooth, c);
    voltage_total    = voltage_total + block_sum_t'(voltage_smooth);
    current_total    = current_total + block_sum_t'(current_smooth);
    samples_in_block = samples_in_block + 1'b1;
    // A block length lowered mid-block still closes the block on the next sample.
    if (int'(samples_in_block) >= len) begin
      due.voltage = scale_reading(voltage_total, regs.voltage_gain, regs.voltage_offset, len);
      due.current = scale_reading(current_total, regs.current_gain, regs.current_offset, len);
      pending_readings.push_back(due);
      voltage_total    = '0;
      current_total    = '0;
      samples_in_block = '0;
    end
  endfunction

  function void note_failure(string what, int unsigned exp_val, int unsigned act_val);
    failures++;
    if (failures <= 10)
      $display("%s: expected %0d, got %0d", what, exp_val, act_val);
  endfunction

  function void match_reading(logic [ebam_pkg::OUT_TDATA_W-1:0] tdata);
    reading_pair_t got;
    reading_pair_t want;
    got = tdata;
    if (pending_readings.size() == 0) begin
      note_failure("reading with none pending, voltage", 0, got.voltage);
      return;
    end
    want = pending_readings.pop_front();
    readings_matched++;
    if (got.voltage !== want.voltage)
      note_failure("voltage_reading mismatch", want.voltage, got.voltage);
    if (got.current !== want.current)
      note_failure("current_reading mismatch", want.current, got.current);
  endfunction
endclass

module tb_ema_block_average_meter;
  import ebam_pkg::*;

  localparam int RUN_LIMIT    = 1_000_000;
  localparam int SETTLE_WAIT  = 60;
  localparam int TARGET_ITEMS = 950;

  // Indexes outside the register map; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef enum {PACE_FREE, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} pace_e;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;

  ema_reading_tracker meter = new();

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_request   = 0;
  int hold_left      = 0;
  int samples_sent   = 0;
  int cycles         = 0;

  ema_block_average_meter u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("tb_ema_block_average_meter: errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      meter.match_reading(m_axis_tdata);
  end

  // Receiver side: random stalls, or a long hold-off when one is requested.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (recv_stall_pct > 0 && $urandom_range(0, 99) < recv_stall_pct) begin
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic set_pace(pace_e pace);
    case (pace)
      PACE_FREE:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      PACE_SEND_IDLE:  begin send_idle_pct = 74; recv_stall_pct = 0;  end
      PACE_RECV_STALL: begin send_idle_pct = 0;  recv_stall_pct = 74; end
      default:         begin send_idle_pct = 10; recv_stall_pct = 10; end
    endcase
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    meter.load_register(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_sample(logic [SAMPLE_BITS-1:0] v, logic [SAMPLE_BITS-1:0] c);
    while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'({c, v});
    do @(posedge clk_i); while (!s_axis_tready);
    meter.take_sample(v, c);
    samples_sent++;
  endtask

  // Stop offering samples, let every pending reading arrive, then let the pipeline empty.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (meter.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return SAMPLE_BITS'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic logic [OFFSET_W-1:0] pick_offset();
    case ($urandom_range(0, 5))
      0:       return 11'h400;
      1:       return 11'h3FF;
      2:       return '0;
      default: return OFFSET_W'($urandom);
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  task automatic configure_random();
    logic [Q_BITS-1:0] q;
    logic [LEN_W-1:0]  len;
    int                pick;
    pick = $urandom_range(0, 9);
    if (pick == 0)      q = '0;
    else if (pick == 1) q = '1;
    else if (pick < 6)  q = Q_BITS'($urandom_range(1000, 20000));
    else                q = Q_BITS'($urandom);
    pick = $urandom_range(0, 19);
    if (pick == 0)       len = '0;
    else if (pick < 3)   len = '1;
    else if (pick < 6)   len = LEN_W'($urandom_range(7, 40));
    else                 len = LEN_W'($urandom_range(1, 6));
    write_reg(REG_SMOOTHING_FACTOR, q);
    write_reg(REG_BLOCK_LENGTH, {8'($urandom), len});
    write_reg(REG_VOLTAGE_GAIN, {2'($urandom), pick_gain()});
    write_reg(REG_VOLTAGE_OFFSET, {5'($urandom), pick_offset()});
    write_reg(REG_CURRENT_GAIN, {2'($urandom), pick_gain()});
    write_reg(REG_CURRENT_OFFSET, {5'($urandom), pick_offset()});
    if ($urandom_range(0, 3) == 0)
      write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, 16'($urandom));
  endtask

  initial begin
    int phase;
    int burst;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Extremes of samples and registers; a zero gain with a negative offset clamps to zero.
    write_reg(REG_SMOOTHING_FACTOR, 16'hFFFF);
    write_reg(REG_BLOCK_LENGTH, 16'd1);
    write_reg(REG_VOLTAGE_GAIN, 16'd16383);
    write_reg(REG_VOLTAGE_OFFSET, 16'd1023);
    write_reg(REG_CURRENT_GAIN, 16'd0);
    write_reg(REG_CURRENT_OFFSET, 16'hFC00);
    send_sample(12'hFFF, 12'h000);
    send_sample(12'h000, 12'hFFF);
    send_sample(12'hFFF, 12'hFFF);
    send_sample(12'h000, 12'h000);
    drain();

    // A zero weight freezes the smoother.
    write_reg(REG_SMOOTHING_FACTOR, 16'd0);
    write_reg(REG_BLOCK_LENGTH, 16'd2);
    write_reg(REG_VOLTAGE_OFFSET, 16'd0);
    write_reg(REG_CURRENT_GAIN, 16'd3289);
    send_sample(12'hFFF, 12'hFFF);
    send_sample(12'd123, 12'd3000);
    drain();

    // Long block cut short: the sum of six full-scale samples overflows the reading.
    write_reg(REG_SMOOTHING_FACTOR, 16'hFFFF);
    write_reg(REG_BLOCK_LENGTH, 16'd255);
    write_reg(REG_CURRENT_GAIN, 16'd16383);
    write_reg(REG_CURRENT_OFFSET, 16'd1023);
    repeat (5) send_sample(12'hFFF, 12'hFFF);
    drain();
    write_reg(REG_BLOCK_LENGTH, 16'd1);
    send_sample(12'hFFF, 12'hFFF);
    drain();

    // Zero block length behaves as one; upper data bits and spare indexes are ignored.
    write_reg(REG_BLOCK_LENGTH, 16'hFF00);
    write_reg(REG_SMOOTHING_FACTOR, 16'd3277);
    write_reg(REG_SPARE_6, 16'hFFFF);
    write_reg(REG_SPARE_7, 16'hA5A5);
    send_sample(12'hA5A, 12'h5A5);
    send_sample(12'h5A5, 12'hA5A);
    drain();

    // Receiver holds off while samples keep coming, so the block fills and stalls its input.
    set_pace(PACE_FREE);
    hold_request = 600;
    repeat (12) send_sample(pick_sample(), pick_sample());
    drain();

    phase = 0;
    while (samples_sent < TARGET_ITEMS) begin
      configure_random();
      set_pace(pace_e'(phase % 4));
      burst = $urandom_range(20, 60);
      repeat (burst) send_sample(pick_sample(), pick_sample());
      drain();
      phase++;
    end

    set_pace(PACE_FREE);
    drain();
    if (meter.pending() != 0)
      meter.note_failure("readings never delivered", 0, meter.pending());
    if (meter.failures == 0)
      $display("tb_ema_block_average_meter: clean");
    else
      $display("tb_ema_block_average_meter: errors");
    $finish;
  end

endmodule
